// File: src/crcfr_pkg.sv
package crcfr_pkg;

    // Result status codes.
    localparam logic [1:0] ST_GOOD     = 2'd0;
    localparam logic [1:0] ST_CRC_BAD  = 2'd1;
    localparam logic [1:0] ST_LEN_OVF  = 2'd2;
    localparam logic [1:0] ST_ABORTED  = 2'd3;

    // Frame type codes.
    localparam logic [1:0] FT_HOST      = 2'd0;
    localparam logic [1:0] FT_RESP      = 2'd1;
    localparam logic [1:0] FT_BROADCAST = 2'd2;

    // Input kind codes.
    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_ABORT = 1'b1;

    // Configuration register indexes.
    localparam logic [2:0] CFG_HOST_FIRST  = 3'd0;
    localparam logic [2:0] CFG_HOST_SECOND = 3'd1;
    localparam logic [2:0] CFG_RESP_FIRST  = 3'd2;
    localparam logic [2:0] CFG_RESP_SECOND = 3'd3;
    localparam logic [2:0] CFG_BCST_FIRST  = 3'd4;
    localparam logic [2:0] CFG_BCST_SECOND = 3'd5;
    localparam logic [2:0] CFG_CRC_SEED    = 3'd6;
    localparam logic [2:0] CFG_PAY_LIMIT   = 3'd7;

    localparam logic [15:0] CRC_SEED_RST  = 16'hFFFF;
    localparam logic [6:0]  PAY_LIMIT_RST = 7'd32;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  frame_type;
        logic [15:0] command;
        logic [15:0] payload_length;
        logic [7:0]  data_byte;
        logic [5:0]  byte_index;
        logic        has_data;
        logic        last;
    } t_out_item;

    // Event handed from the parser to the result sequencer.
    typedef struct packed {
        logic        valid;
        logic        replay;
        logic [1:0]  status;
        logic [1:0]  frame_type;
        logic [15:0] command;
        logic [15:0] length;
    } t_evt;

endpackage

// File: src/crc16_frame_receiver_core.sv
// Channel   | Direction | Signals                              | Transfer when
// ----------+-----------+--------------------------------------+------------------------------
// input     | in        | i_in_valid, o_in_stall, i_in_data    | i_in_valid && !o_in_stall
// result    | out       | o_out_valid, i_out_stall, o_out_data | o_out_valid && !i_out_stall
// config    | in        | i_cfg_we, i_cfg_index, i_cfg_data    | i_cfg_we
//
// A received byte or abort is taken whenever the input is not stalled; the parser keeps its scalar state in flops.
// An input that ends in a status result stalls the input while the sequencer passes its
// status state, which writes the result to the output register; a good frame stalls the input
// while its payload is replayed, each byte passing a read state and then an emit state.
// Reset is synchronous and active low; the payload memory is not cleared and needs no pass.
// A stalled result holds the output register; a later event then waits and holds off input.
module crc16_frame_receiver_core #(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  crcfr_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output crcfr_pkg::t_out_item o_out_data,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic            busy;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [7:0]      wr_data;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic [7:0]      rd_data;
    crcfr_pkg::t_evt evt;

    // The input is held off while the sequencer owns an event, so the parser never
    // writes the payload memory while a frame is being replayed from it.
    assign o_in_stall = busy;

    crcfr_parser #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .i_busy     (busy),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_evt      (evt)
    );

    // Payload store: written in order during the payload bytes, read back for replay.
    crcfr_ram #(
        .WIDTH(8),
        .DEPTH(MAX_PAYLOAD)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (wr_en),
        .i_waddr(wr_addr),
        .i_wdata(wr_data),
        .i_re   (rd_en),
        .i_raddr(rd_addr),
        .o_rdata(rd_data)
    );

    crcfr_replay #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_replay (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_evt      (evt),
        .o_busy     (busy),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data),
        .i_out_stall(i_out_stall),
        .o_out_valid(o_out_valid),
        .o_out_data (o_out_data)
    );

endmodule

// File: src/crcfr_ram.sv
module crcfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/crcfr_parser.sv
module crcfr_parser #(
    parameter int MAX_PAYLOAD = 64,
    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1,
    localparam int CW = $clog2(MAX_PAYLOAD + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_in_valid,
    input  crcfr_pkg::t_in_item i_in_data,
    input  logic               i_busy,
    output logic               o_wr_en,
    output logic [AW-1:0]      o_wr_addr,
    output logic [7:0]         o_wr_data,
    output crcfr_pkg::t_evt    o_evt
);

    typedef enum logic [8:0] {
        PH_IDLE    = 9'b000000001,
        PH_HDR2    = 9'b000000010,
        PH_CMD_LO  = 9'b000000100,
        PH_CMD_HI  = 9'b000001000,
        PH_LEN_LO  = 9'b000010000,
        PH_LEN_HI  = 9'b000100000,
        PH_PAYLOAD = 9'b001000000,
        PH_CRC_LO  = 9'b010000000,
        PH_CRC_HI  = 9'b100000000
    } t_phase;

    // CRC-16, polynomial 0x1021, MSB first, one byte.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    logic [7:0]  r_host_first, r_host_second;
    logic [7:0]  r_resp_first, r_resp_second;
    logic [7:0]  r_bcst_first, r_bcst_second;
    logic [15:0] r_seed;
    logic [6:0]  r_limit;

    t_phase      r_phase, n_phase;
    logic [1:0]  r_type, n_type;
    logic [15:0] r_crc, n_crc;
    logic [15:0] r_cmd, n_cmd;
    logic [15:0] r_len, n_len;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [7:0]  r_crc_lo, n_crc_lo;

    logic        accept;
    logic [7:0]  b;
    logic        fh_hit;
    logic [1:0]  fh_type;
    logic [7:0]  second_exp;
    logic [6:0]  eff_limit;
    logic [CW-1:0] cnt_inc;

    assign accept = i_in_valid && !i_busy;
    assign b      = i_in_data.rx_byte;

    always_comb begin
        fh_hit  = 1'b1;
        fh_type = crcfr_pkg::FT_HOST;
        if (b == r_host_first) begin
            fh_type = crcfr_pkg::FT_HOST;
        end else if (b == r_resp_first) begin
            fh_type = crcfr_pkg::FT_RESP;
        end else if (b == r_bcst_first) begin
            fh_type = crcfr_pkg::FT_BROADCAST;
        end else begin
            fh_hit = 1'b0;
        end
    end

    always_comb begin
        case (r_type)
            crcfr_pkg::FT_HOST: second_exp = r_host_second;
            crcfr_pkg::FT_RESP: second_exp = r_resp_second;
            default:            second_exp = r_bcst_second;
        endcase
    end

    assign eff_limit = (r_limit < 7'(MAX_PAYLOAD)) ? r_limit : 7'(MAX_PAYLOAD);
    assign cnt_inc   = r_cnt + 1'b1;

    always_comb begin
        n_phase  = r_phase;
        n_type   = r_type;
        n_crc    = r_crc;
        n_cmd    = r_cmd;
        n_len    = r_len;
        n_cnt    = r_cnt;
        n_crc_lo = r_crc_lo;
        o_wr_en   = 1'b0;
        o_wr_addr = r_cnt[AW-1:0];
        o_wr_data = b;
        o_evt     = '0;

        if (accept) begin
            if (i_in_data.kind == crcfr_pkg::KIND_ABORT) begin
                if (r_phase != PH_IDLE) begin
                    o_evt.valid  = 1'b1;
                    o_evt.status = crcfr_pkg::ST_ABORTED;
                end
                n_phase = PH_IDLE;
            end else begin
                case (r_phase)
                    PH_IDLE, PH_HDR2: begin
                        if (r_phase == PH_HDR2 && b == second_exp) begin
                            n_crc   = crc_byte(r_crc, b);
                            n_phase = PH_CMD_LO;
                        end else if (fh_hit) begin
                            // A wrong second byte is tried again as a first byte.
                            n_type  = fh_type;
                            n_crc   = crc_byte(r_seed, b);
                            n_cmd   = '0;
                            n_len   = '0;
                            n_phase = PH_HDR2;
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end
                    PH_CMD_LO: begin
                        n_cmd   = {8'h00, b};
                        n_crc   = crc_byte(r_crc, b);
                        n_phase = PH_CMD_HI;
                    end
                    PH_CMD_HI: begin
                        n_cmd   = {b, r_cmd[7:0]};
                        n_crc   = crc_byte(r_crc, b);
                        n_phase = PH_LEN_LO;
                    end
                    PH_LEN_LO: begin
                        n_len   = {8'h00, b};
                        n_crc   = crc_byte(r_crc, b);
                        n_phase = PH_LEN_HI;
                    end
                    PH_LEN_HI: begin
                        n_len = {b, r_len[7:0]};
                        n_crc = crc_byte(r_crc, b);
                        if (n_len > {9'd0, eff_limit}) begin
                            o_evt.valid  = 1'b1;
                            o_evt.status = crcfr_pkg::ST_LEN_OVF;
                            n_phase      = PH_IDLE;
                        end else begin
                            n_cnt   = '0;
                            n_phase = (n_len == 16'd0) ? PH_CRC_LO : PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD: begin
                        o_wr_en = 1'b1;
                        n_cnt   = cnt_inc;
                        n_crc   = crc_byte(r_crc, b);
                        if (16'(cnt_inc) >= r_len) begin
                            n_phase = PH_CRC_LO;
                        end
                    end
                    PH_CRC_LO: begin
                        n_crc_lo = b;
                        n_phase  = PH_CRC_HI;
                    end
                    PH_CRC_HI: begin
                        n_phase     = PH_IDLE;
                        o_evt.valid = 1'b1;
                        if (r_crc != {b, r_crc_lo}) begin
                            o_evt.status = crcfr_pkg::ST_CRC_BAD;
                        end else begin
                            o_evt.status = crcfr_pkg::ST_GOOD;
                            o_evt.replay = (r_len != 16'd0);
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end

        o_evt.frame_type = n_type;
        o_evt.command    = n_cmd;
        o_evt.length     = n_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_host_first  <= '0;
            r_host_second <= '0;
            r_resp_first  <= '0;
            r_resp_second <= '0;
            r_bcst_first  <= '0;
            r_bcst_second <= '0;
            r_seed        <= crcfr_pkg::CRC_SEED_RST;
            r_limit       <= crcfr_pkg::PAY_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                crcfr_pkg::CFG_HOST_FIRST:  r_host_first  <= i_cfg_data[7:0];
                crcfr_pkg::CFG_HOST_SECOND: r_host_second <= i_cfg_data[7:0];
                crcfr_pkg::CFG_RESP_FIRST:  r_resp_first  <= i_cfg_data[7:0];
                crcfr_pkg::CFG_RESP_SECOND: r_resp_second <= i_cfg_data[7:0];
                crcfr_pkg::CFG_BCST_FIRST:  r_bcst_first  <= i_cfg_data[7:0];
                crcfr_pkg::CFG_BCST_SECOND: r_bcst_second <= i_cfg_data[7:0];
                crcfr_pkg::CFG_CRC_SEED:    r_seed        <= i_cfg_data;
                crcfr_pkg::CFG_PAY_LIMIT:   r_limit       <= i_cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_type   <= '0;
            r_crc    <= '0;
            r_cmd    <= '0;
            r_len    <= '0;
            r_cnt    <= '0;
            r_crc_lo <= '0;
        end else begin
            r_phase  <= n_phase;
            r_type   <= n_type;
            r_crc    <= n_crc;
            r_cmd    <= n_cmd;
            r_len    <= n_len;
            r_cnt    <= n_cnt;
            r_crc_lo <= n_crc_lo;
        end
    end

endmodule

// File: src/crcfr_replay.sv
module crcfr_replay #(
    parameter int MAX_PAYLOAD = 64,
    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1,
    localparam int CW = $clog2(MAX_PAYLOAD + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  crcfr_pkg::t_evt      i_evt,
    output logic                 o_busy,
    output logic                 o_rd_en,
    output logic [AW-1:0]        o_rd_addr,
    input  logic [7:0]           i_rd_data,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output crcfr_pkg::t_out_item o_out_data
);

    typedef enum logic [3:0] {
        RP_IDLE = 4'b0001,
        RP_STAT = 4'b0010,
        RP_READ = 4'b0100,
        RP_EMIT = 4'b1000
    } t_rp_state;

    t_rp_state            r_state, n_state;
    crcfr_pkg::t_evt      r_evt, n_evt;
    logic [CW-1:0]        r_idx, n_idx;
    logic                 r_out_valid, n_out_valid;
    crcfr_pkg::t_out_item r_out, n_out;

    logic          out_free;
    logic [CW-1:0] idx_inc;
    logic          is_last;

    assign out_free = !r_out_valid || !i_out_stall;
    assign idx_inc  = r_idx + 1'b1;
    assign is_last  = (16'(idx_inc) == r_evt.length);

    assign o_busy    = (r_state != RP_IDLE);
    assign o_rd_en   = (r_state == RP_READ);
    assign o_rd_addr = r_idx[AW-1:0];

    always_comb begin
        n_state     = r_state;
        n_evt       = r_evt;
        n_idx       = r_idx;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;

        case (r_state)
            RP_IDLE: begin
                if (i_evt.valid) begin
                    n_evt   = i_evt;
                    n_idx   = '0;
                    n_state = i_evt.replay ? RP_READ : RP_STAT;
                end
            end
            RP_STAT: begin
                if (out_free) begin
                    n_out.status         = r_evt.status;
                    n_out.frame_type     = r_evt.frame_type;
                    n_out.command        = r_evt.command;
                    n_out.payload_length = r_evt.length;
                    n_out.data_byte      = '0;
                    n_out.byte_index     = '0;
                    n_out.has_data       = 1'b0;
                    n_out.last           = 1'b1;
                    n_out_valid          = 1'b1;
                    n_state              = RP_IDLE;
                end
            end
            RP_READ: begin
                n_state = RP_EMIT;
            end
            RP_EMIT: begin
                if (out_free) begin
                    n_out.status         = crcfr_pkg::ST_GOOD;
                    n_out.frame_type     = r_evt.frame_type;
                    n_out.command        = r_evt.command;
                    n_out.payload_length = r_evt.length;
                    n_out.data_byte      = i_rd_data;
                    n_out.byte_index     = 6'(r_idx);
                    n_out.has_data       = 1'b1;
                    n_out.last           = is_last;
                    n_out_valid          = 1'b1;
                    n_idx                = idx_inc;
                    n_state              = is_last ? RP_IDLE : RP_READ;
                end
            end
            default: begin
                n_state = RP_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= RP_IDLE;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_evt <= n_evt;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: src/crcfr_checker.sv
module crcfr_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input crcfr_pkg::t_out_item o_out_data
);

    // A stalled result is held unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // Every result with a status other than good is a single, final transfer.
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != crcfr_pkg::ST_GOOD |->
            o_out_data.last && !o_out_data.has_data)
        else $error("status result not single and last");

    // Results without a payload byte carry zero data and index.
    a_nodata_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.has_data |->
            o_out_data.data_byte == 8'd0 && o_out_data.byte_index == 6'd0)
        else $error("data fields set without payload byte");

    // A payload byte that is not last is followed by the next index of the same frame.
    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && o_out_data.has_data && !o_out_data.last
            ##1 o_out_valid |->
            o_out_data.has_data && o_out_data.byte_index == $past(o_out_data.byte_index) + 6'd1)
        else $error("payload replay skipped or repeated a byte");

    // Nothing is offered right after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind crc16_frame_receiver_core crcfr_checker u_crcfr_checker (.*);

// File: tb/crc16_frame_receiver_core_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the framed CRC-16 receiver.
// The stimulus process builds byte streams: whole frames with random content,
// frames with a corrupted CRC, oversized lengths, aborts in mid-frame, stray
// header bytes and noise. A driver process offers them one transfer at a time.
// Every accepted input transfer is run through a parser model kept in this file.
// That model queues the result transfers the block should produce. A monitor
// process checks each result transfer against the oldest queued one.
module crc16_frame_receiver_core_tb;
    import crcfr_pkg::*;

    localparam int          MAX_PAYLOAD = 64;
    localparam int          CLK_HALF    = 10;
    localparam int          LONG_HOLD   = 300;
    localparam logic [15:0] CRC_POLY    = 16'h1021;

    // Parser phases of the model, in the order a frame passes through them.
    typedef enum logic [3:0] {
        RX_IDLE, RX_HDR2, RX_CMD_LO, RX_CMD_HI, RX_LEN_LO, RX_LEN_HI,
        RX_PAYLOAD, RX_CRC_LO, RX_CRC_HI
    } t_rx_phase;

    logic        i_clk;
    logic        i_rst_n   = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    t_in_item    in_data   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out_item   out_data;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_index = CFG_HOST_FIRST;
    logic [15:0] cfg_data  = '0;

    // Register values as the block holds them.
    logic [7:0]  hdr_first [3];
    logic [7:0]  hdr_second [3];
    logic [15:0] crc_seed_reg;
    logic [6:0]  pay_limit_reg;

    // Parser state of the model.
    t_rx_phase   rx_phase;
    logic [1:0]  cur_type;
    logic [15:0] crc_acc;
    logic [15:0] cmd_acc;
    logic [15:0] len_acc;
    logic [6:0]  pay_count;
    logic [7:0]  crc_low_rx;
    logic [7:0]  payload_mem [MAX_PAYLOAD];

    // Bytes and aborts waiting to be offered, and results still owed by the block.
    t_in_item    rx_items_q [$];
    t_out_item   frame_results_q [$];

    int items_queued   = 0;
    int items_accepted = 0;
    int results_seen   = 0;
    int error_count    = 0;
    int held_off       = 0;
    int status_seen [4] = '{0, 0, 0, 0};

    // Idle rates in percent, and the long hold-off handshake with the receiver.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int holds_asked    = 0;
    int holds_given    = 0;
    int hold_left      = 0;

    crc16_frame_receiver_core #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // CRC-16 with polynomial 0x1021, most significant bit first, one byte at a time.
    function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    // The length limit in force is never above the payload memory depth.
    function automatic int eff_limit();
        return (int'(pay_limit_reg) < MAX_PAYLOAD) ? int'(pay_limit_reg) : MAX_PAYLOAD;
    endfunction

    // A byte seen while idle opens a frame if it matches a first header byte.
    // When several first bytes are equal, host beats response and response
    // beats broadcast.
    task automatic open_header(input logic [7:0] b);
        logic hit;
        hit = 1'b1;
        if (b == hdr_first[FT_HOST]) cur_type = FT_HOST;
        else if (b == hdr_first[FT_RESP]) cur_type = FT_RESP;
        else if (b == hdr_first[FT_BROADCAST]) cur_type = FT_BROADCAST;
        else hit = 1'b0;
        if (hit) begin
            crc_acc  = crc16_update(crc_seed_reg, b);
            cmd_acc  = '0;
            len_acc  = '0;
            rx_phase = RX_HDR2;
        end
    endtask

    // Status results carry the frame fields gathered so far and no payload.
    task automatic owe_status(input logic [1:0] st);
        t_out_item r;
        r                = '0;
        r.status         = st;
        r.frame_type     = cur_type;
        r.command        = cmd_acc;
        r.payload_length = len_acc;
        r.last           = 1'b1;
        frame_results_q.push_back(r);
    endtask

    // Advances the parser model by one accepted input transfer.
    task automatic parse_rx_item(input t_in_item it);
        t_out_item  r;
        logic [7:0] b;
        int         n;
        b = it.rx_byte;
        if (it.kind == KIND_ABORT) begin
            // An abort only matters once a header has been seen.
            if (rx_phase != RX_IDLE) begin
                rx_phase = RX_IDLE;
                owe_status(ST_ABORTED);
            end
            return;
        end
        case (rx_phase)
            RX_IDLE: begin
                open_header(b);
            end
            RX_HDR2: begin
                if (b == hdr_second[cur_type]) begin
                    crc_acc  = crc16_update(crc_acc, b);
                    rx_phase = RX_CMD_LO;
                end else begin
                    // A wrong second byte may itself start a new frame.
                    rx_phase = RX_IDLE;
                    open_header(b);
                end
            end
            RX_CMD_LO: begin
                cmd_acc  = {8'h00, b};
                crc_acc  = crc16_update(crc_acc, b);
                rx_phase = RX_CMD_HI;
            end
            RX_CMD_HI: begin
                cmd_acc[15:8] = b;
                crc_acc       = crc16_update(crc_acc, b);
                rx_phase      = RX_LEN_LO;
            end
            RX_LEN_LO: begin
                len_acc  = {8'h00, b};
                crc_acc  = crc16_update(crc_acc, b);
                rx_phase = RX_LEN_HI;
            end
            RX_LEN_HI: begin
                len_acc[15:8] = b;
                crc_acc       = crc16_update(crc_acc, b);
                if (int'(len_acc) > eff_limit()) begin
                    rx_phase = RX_IDLE;
                    owe_status(ST_LEN_OVF);
                end else begin
                    pay_count = '0;
                    rx_phase  = (len_acc == 16'd0) ? RX_CRC_LO : RX_PAYLOAD;
                end
            end
            RX_PAYLOAD: begin
                if (int'(pay_count) < MAX_PAYLOAD) payload_mem[pay_count[5:0]] = b;
                pay_count = pay_count + 7'd1;
                crc_acc   = crc16_update(crc_acc, b);
                if ({9'd0, pay_count} >= len_acc) rx_phase = RX_CRC_LO;
            end
            RX_CRC_LO: begin
                crc_low_rx = b;
                rx_phase   = RX_CRC_HI;
            end
            RX_CRC_HI: begin
                rx_phase = RX_IDLE;
                if (crc_acc != {b, crc_low_rx}) begin
                    owe_status(ST_CRC_BAD);
                end else if (len_acc == 16'd0) begin
                    owe_status(ST_GOOD);
                end else begin
                    // A good frame is replayed one payload byte per result.
                    n = (int'(len_acc) < MAX_PAYLOAD) ? int'(len_acc) : MAX_PAYLOAD;
                    for (int i = 0; i < n; i++) begin
                        r                = '0;
                        r.status         = ST_GOOD;
                        r.frame_type     = cur_type;
                        r.command        = cmd_acc;
                        r.payload_length = len_acc;
                        r.data_byte      = payload_mem[i];
                        r.byte_index     = 6'(i);
                        r.has_data       = 1'b1;
                        r.last           = (i == n - 1);
                        frame_results_q.push_back(r);
                    end
                end
            end
            default: begin
                rx_phase = RX_IDLE;
            end
        endcase
    endtask

    task automatic queue_byte(input logic [7:0] b);
        t_in_item it;
        it.kind    = KIND_BYTE;
        it.rx_byte = b;
        rx_items_q.push_back(it);
        items_queued++;
    endtask

    // The byte field of an abort is don't-care, so it gets random content.
    task automatic queue_abort();
        t_in_item it;
        it.kind    = KIND_ABORT;
        it.rx_byte = 8'($urandom);
        rx_items_q.push_back(it);
        items_queued++;
    endtask

    // Builds a frame from the current header registers and CRC seed. An oversized
    // length ends the frame after the length field, as the parser drops out there.
    // A negative cut position or one at or past the end sends the whole frame; otherwise the frame
    // is broken off by an abort after that many bytes.
    task automatic queue_frame(input logic [1:0] ft, input logic [15:0] cmd,
                               input logic [15:0] len, input int cut, input logic bad_crc);
        logic [7:0]  frame_bytes [$];
        logic [15:0] crc;
        frame_bytes.push_back(hdr_first[ft]);
        frame_bytes.push_back(hdr_second[ft]);
        frame_bytes.push_back(cmd[7:0]);
        frame_bytes.push_back(cmd[15:8]);
        frame_bytes.push_back(len[7:0]);
        frame_bytes.push_back(len[15:8]);
        if (int'(len) <= eff_limit()) begin
            repeat (int'(len)) frame_bytes.push_back(8'($urandom));
            crc = crc_seed_reg;
            foreach (frame_bytes[i]) crc = crc16_update(crc, frame_bytes[i]);
            if (bad_crc) crc = crc ^ (16'd1 << $urandom_range(15));
            frame_bytes.push_back(crc[7:0]);
            frame_bytes.push_back(crc[15:8]);
        end
        foreach (frame_bytes[i]) begin
            if (i == cut) begin
                queue_abort();
                return;
            end
            queue_byte(frame_bytes[i]);
        end
    endtask

    // Mostly well-formed frames with random content; the rest are broken
    // sequences and noise. Large payloads are rare except for the requested
    // full-size frames at the start.
    task automatic queue_random_traffic(input int budget, input int full_frames);
        int         start_count;
        int         pick;
        int         eff;
        int         len;
        logic [1:0] ft;
        start_count = items_queued;
        eff         = eff_limit();
        repeat (full_frames) queue_frame(2'($urandom_range(2)), 16'($urandom), 16'(eff), -1, 1'b0);
        while (items_queued - start_count < budget) begin
            pick = $urandom_range(99);
            ft   = 2'($urandom_range(2));
            len  = ($urandom_range(7) == 0) ? $urandom_range(eff) : $urandom_range(eff < 6 ? eff : 6);
            if (pick < 58) begin
                queue_frame(ft, 16'($urandom), 16'(len), -1, 1'b0);
            end else if (pick < 68) begin
                queue_frame(ft, 16'($urandom), 16'(len), -1, 1'b1);
            end else if (pick < 76) begin
                queue_frame(ft, 16'($urandom), 16'($urandom_range(16'hFFFF, eff + 1)), -1, 1'b0);
            end else if (pick < 84) begin
                queue_frame(ft, 16'($urandom), 16'(len), $urandom_range(len + 7, 1), 1'b0);
            end else if (pick < 92) begin
                // A lone first header byte, then a frame of another type whose first
                // byte lands on the second header position.
                queue_byte(hdr_first[ft]);
                queue_frame(2'((int'(ft) + 1 + $urandom_range(1)) % 3), 16'($urandom),
                            16'(len), -1, 1'b0);
            end else begin
                repeat ($urandom_range(4, 1)) queue_byte(8'($urandom));
                queue_abort();
            end
        end
        // A closing abort leaves the parser idle before the registers change.
        queue_abort();
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_HOST_FIRST:  hdr_first[FT_HOST]       = val[7:0];
            CFG_HOST_SECOND: hdr_second[FT_HOST]      = val[7:0];
            CFG_RESP_FIRST:  hdr_first[FT_RESP]       = val[7:0];
            CFG_RESP_SECOND: hdr_second[FT_RESP]      = val[7:0];
            CFG_BCST_FIRST:  hdr_first[FT_BROADCAST]  = val[7:0];
            CFG_BCST_SECOND: hdr_second[FT_BROADCAST] = val[7:0];
            CFG_CRC_SEED:    crc_seed_reg             = val;
            CFG_PAY_LIMIT:   pay_limit_reg            = val[6:0];
            default: ;
        endcase
    endtask

    task automatic apply_config(input logic [7:0] host_1, input logic [7:0] host_2,
                                input logic [7:0] resp_1, input logic [7:0] resp_2,
                                input logic [7:0] bcst_1, input logic [7:0] bcst_2,
                                input logic [15:0] seed, input logic [6:0] limit);
        write_reg(CFG_HOST_FIRST, {8'h00, host_1});
        write_reg(CFG_HOST_SECOND, {8'h00, host_2});
        write_reg(CFG_RESP_FIRST, {8'h00, resp_1});
        write_reg(CFG_RESP_SECOND, {8'h00, resp_2});
        write_reg(CFG_BCST_FIRST, {8'h00, bcst_1});
        write_reg(CFG_BCST_SECOND, {8'h00, bcst_2});
        write_reg(CFG_CRC_SEED, seed);
        write_reg(CFG_PAY_LIMIT, {9'd0, limit});
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Waits until every queued item has been taken and every owed result has
    // arrived, then lets the block settle.
    task automatic wait_drained();
        @(negedge i_clk);
        while (items_accepted != items_queued || frame_results_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (8) @(negedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endtask

    // Driver: a new item is offered only when the previous one has been taken or
    // nothing is on offer, so a stalled payload holds still.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !in_stall) begin
            if (in_valid) begin
                parse_rx_item(in_data);
                items_accepted++;
            end
            if (rx_items_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                in_valid <= 1'b1;
                in_data  <= rx_items_q.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever the stimulus asks.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (holds_given != holds_asked) begin
                hold_left = LONG_HOLD;
                holds_given++;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // Monitor: every result transfer must match the oldest owed result.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (in_valid && in_stall) held_off++;
            if (out_valid && !out_stall) begin
                if (frame_results_q.size() == 0) begin
                    $error("result transfer with nothing owed: status %0d command 0x%0h",
                           out_data.status, out_data.command);
                    error_count++;
                end else begin
                    want = frame_results_q.pop_front();
                    check_field("status", 16'(want.status), 16'(out_data.status));
                    check_field("frame_type", 16'(want.frame_type), 16'(out_data.frame_type));
                    check_field("command", want.command, out_data.command);
                    check_field("payload_length", want.payload_length, out_data.payload_length);
                    check_field("data_byte", 16'(want.data_byte), 16'(out_data.data_byte));
                    check_field("byte_index", 16'(want.byte_index), 16'(out_data.byte_index));
                    check_field("has_data", 16'(want.has_data), 16'(out_data.has_data));
                    check_field("last", 16'(want.last), 16'(out_data.last));
                    results_seen++;
                    status_seen[want.status]++;
                end
            end
        end
    end

    // Stimulus and phase sequencing.
    initial begin
        hdr_first     = '{8'h00, 8'h00, 8'h00};
        hdr_second    = '{8'h00, 8'h00, 8'h00};
        crc_seed_reg  = CRC_SEED_RST;
        pay_limit_reg = PAY_LIMIT_RST;
        rx_phase      = RX_IDLE;
        cur_type      = FT_HOST;
        crc_acc       = '0;
        cmd_acc       = '0;
        len_acc       = '0;
        pay_count     = '0;
        crc_low_rx    = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Phase one: the sender idles rarely and the receiver stalls often.
        send_idle_pct  = 16;
        recv_stall_pct = 68;

        // Host and response share a first byte, so host must win it.
        apply_config(8'hA5, 8'h5A, 8'hA5, 8'hC3, 8'h7E, 8'h81, 16'hFFFF, 7'd64);
        queue_abort();                                          // abort while idle
        queue_frame(FT_HOST, 16'hFFFF, 16'd0, -1, 1'b0);        // good, no payload
        queue_byte(8'hA5);                                      // host by priority,
        queue_byte(8'hC3);                                      // then a wrong second byte
        queue_byte(8'hA5);                                      // wrong second byte that
        queue_frame(FT_BROADCAST, 16'h0000, 16'd0, -1, 1'b1);   // opens a frame; bad CRC
        queue_frame(FT_HOST, 16'h8001, 16'hFFFF, -1, 1'b0);     // length overflow
        queue_frame(FT_HOST, 16'h1234, 16'd2, 4, 1'b0);         // abort after the command
        queue_frame(FT_RESP, 16'h00FF, 16'd1, -1, 1'b0);        // becomes host, then re-parsed
        queue_frame(FT_BROADCAST, 16'h7F80, 16'd1, -1, 1'b0);   // one-byte good frame
        wait_drained();

        // A full-size frame and random traffic while the receiver holds off, so the block
        // backs up and stalls its input.
        apply_config(8'h00, 8'hFF, 8'hFF, 8'h00, 8'h55, 8'hAA, 16'h0000, 7'd64);
        holds_asked++;
        queue_random_traffic(80, 1);
        wait_drained();

        // Phase two: the sender idles often and the receiver stalls rarely.
        // A zero limit makes every non-empty frame an overflow.
        send_idle_pct  = 68;
        recv_stall_pct = 16;
        apply_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom), 8'($urandom), 16'($urandom), 7'd0);
        queue_random_traffic(50, 0);
        wait_drained();

        // Phase three: no idling on either side.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        apply_config(8'h3C, 8'hC3, 8'h96, 8'h69, 8'hFF, 8'hFF, 16'h1D0F, 7'd7);
        queue_random_traffic(75, 1);
        wait_drained();

        $display("Accepted %0d input transfers and checked %0d result transfers.",
                 items_accepted, results_seen);
        $display("Results: %0d good, %0d crc mismatch, %0d overflow, %0d aborted; %0d %s",
                 status_seen[ST_GOOD], status_seen[ST_CRC_BAD], status_seen[ST_LEN_OVF],
                 status_seen[ST_ABORTED], held_off, "held-off cycles.");
        if (error_count == 0) begin
            $display("crc16_frame_receiver_core_tb: done, clean");
        end else begin
            $display("crc16_frame_receiver_core_tb: done, errors");
        end
        $finish;
    end

    // Watchdog in case the block hangs or drops owed results.
    initial begin
        #40_000_000;
        $display("crc16_frame_receiver_core_tb: done, errors");
        $finish;
    end

endmodule
